[src/sfcb_pkg.sv]
// shared types and status codes for the shannon-fano code builder
// no dependencies
package sfcb_pkg;
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_ZERO     = 2'd2,
    ST_TOO_MANY = 2'd3
  } status_t;
  localparam int CODE_MAX_LEN = 31;
endpackage

[src/shannon_fano_code_builder_unit.sv]
// channel   signals                                        direction
// input     in_valid/in_ready, weight, last                 into block
// output    out_valid/out_ready, symbol_index, code_bits,   out of block
//           code_length, status, last_out
// a stored weight is placed in the sorted store by insertion shifts, a dropped one
// is not stored; on last, a check state and a running-sum pass, then each split
// scans its range one position per cycle through a shared subtract/compare unit
// and applies bits one position per cycle.
// results leave one per cycle through an output register while out_ready is high.
// reset clears control state only; stores are written before they are read.
// depends on sfcb_pkg
module shannon_fano_code_builder_unit import sfcb_pkg::*; #(
  parameter int MAX_SYMBOLS = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [15:0]            weight,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4:0]             symbol_index,
  output logic [30:0]            code_bits,
  output logic [4:0]             code_length,
  output logic [1:0]             status,
  output logic                   last_out
);
  localparam int IW = $clog2(MAX_SYMBOLS);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int SW = WEIGHT_BITS + CW;
  localparam int SD = MAX_SYMBOLS;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_CHECK, S_SUM, S_POP, S_SCAN, S_MARK, S_EMIT, S_ERR
  } state_t;
  state_t state;

  logic [WEIGHT_BITS-1:0] sw_mem [MAX_SYMBOLS];
  logic [IW-1:0]          so_mem [MAX_SYMBOLS];
  // entry k holds the sum of the first k+1 sorted weights; the empty sum is zero
  logic [SW-1:0]          rs_mem [MAX_SYMBOLS];
  logic [30:0]            cd_mem [MAX_SYMBOLS];
  logic [4:0]             ln_mem [MAX_SYMBOLS];
  logic [CW-1:0]          st_lo  [SD];
  logic [CW-1:0]          st_hi  [SD];

  logic [CW-1:0] count, pos, lo, hi, idx, best, sp;
  logic [WEIGHT_BITS-1:0] w_hold;
  logic [1:0] errf;
  logic       is_last;
  logic [SW-1:0] best_diff, acc;
  logic [SW-1:0] left, right, diff;
  logic [SW-1:0] sum_at, sum_lo, sum_hi;

  logic [WEIGHT_BITS-1:0] w_in;
  assign w_in = WEIGHT_BITS'(weight);

  // shared difference unit for the split scan
  always_comb begin
    sum_at = (idx == '0) ? '0 : rs_mem[IW'(idx - 1'b1)];
    sum_lo = (lo == '0) ? '0 : rs_mem[IW'(lo - 1'b1)];
    sum_hi = (hi == '0) ? '0 : rs_mem[IW'(hi - 1'b1)];
    left  = sum_at - sum_lo;
    right = sum_hi - sum_at;
    diff  = (left > right) ? left - right : right - left;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      errf <= '0;
      out_valid <= 1'b0;
      sp <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            is_last <= last;
            w_hold <= w_in;
            if (w_in == '0) errf[0] <= 1'b1;
            if (count < CW'(MAX_SYMBOLS)) begin
              pos <= count;
              state <= S_INS;
            end else begin
              errf[1] <= 1'b1;
              state <= last ? S_CHECK : S_IDLE;
            end
          end
        end
        S_INS: begin
          // one shift of the sorted store per cycle
          if (pos != '0 && sw_mem[IW'(pos - 1'b1)] < w_hold) begin
            sw_mem[IW'(pos)] <= sw_mem[IW'(pos - 1'b1)];
            so_mem[IW'(pos)] <= so_mem[IW'(pos - 1'b1)];
            pos <= pos - 1'b1;
          end else begin
            sw_mem[IW'(pos)] <= w_hold;
            so_mem[IW'(pos)] <= IW'(count);
            count <= count + 1'b1;
            state <= is_last ? S_CHECK : S_IDLE;
          end
        end
        S_CHECK: begin
          if (count < CW'(2)) begin
            status <= ST_TOO_FEW; state <= S_ERR;
          end else if (errf[0]) begin
            status <= ST_ZERO; state <= S_ERR;
          end else if (errf[1]) begin
            status <= ST_TOO_MANY; state <= S_ERR;
          end else begin
            acc <= '0;
            idx <= '0;
            state <= S_SUM;
          end
          errf <= '0;
        end
        S_ERR: begin
          symbol_index <= '0; code_bits <= '0; code_length <= '0;
          last_out <= 1'b1;
          out_valid <= 1'b1;
          count <= '0;
          state <= S_EMIT;
          idx <= '0;
        end
        S_SUM: begin
          rs_mem[IW'(idx)] <= acc + SW'(sw_mem[IW'(idx)]);
          acc <= acc + SW'(sw_mem[IW'(idx)]);
          cd_mem[IW'(idx)] <= '0;
          ln_mem[IW'(idx)] <= '0;
          if (idx == count - 1'b1) begin
            st_lo[0] <= '0; st_hi[0] <= count; sp <= CW'(1);
            state <= S_POP;
          end
          idx <= idx + 1'b1;
        end
        S_POP: begin
          if (sp == '0) begin
            idx <= '0;
            status <= ST_OK;
            state <= S_EMIT;
          end else begin
            lo <= st_lo[IW'(sp - 1'b1)];
            hi <= st_hi[IW'(sp - 1'b1)];
            idx <= st_lo[IW'(sp - 1'b1)] + 1'b1;
            sp <= sp - 1'b1;
            if (st_hi[IW'(sp - 1'b1)] - st_lo[IW'(sp - 1'b1)] >= CW'(2))
              state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == lo + 1'b1 || diff < best_diff) begin
            best <= idx; best_diff <= diff;
          end
          if (idx == hi - 1'b1) state <= S_MARK;
          idx <= (idx == hi - 1'b1) ? lo : idx + 1'b1;
        end
        S_MARK: begin
          if (ln_mem[IW'(idx)] < 5'(CODE_MAX_LEN)) begin
            cd_mem[IW'(idx)] <= {cd_mem[IW'(idx)][29:0], idx < best};
            ln_mem[IW'(idx)] <= ln_mem[IW'(idx)] + 1'b1;
          end
          idx <= idx + 1'b1;
          if (idx == hi - 1'b1) begin
            // upper part pushed first so the lower part is split next
            st_lo[IW'(sp)] <= best; st_hi[IW'(sp)] <= hi;
            st_lo[IW'(sp + 1'b1)] <= lo; st_hi[IW'(sp + 1'b1)] <= best;
            sp <= sp + CW'(2);
            state <= S_POP;
          end
        end
        S_EMIT: begin
          if (status != ST_OK) begin
            if (out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
          end else if (!out_valid || out_ready) begin
            if (out_valid && last_out) begin
              out_valid <= 1'b0; count <= '0; state <= S_IDLE;
            end else begin
              symbol_index <= 5'(so_mem[IW'(idx)]);
              code_bits <= cd_mem[IW'(idx)];
              code_length <= ln_mem[IW'(idx)];
              last_out <= (idx == count - 1'b1);
              out_valid <= 1'b1;
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while results pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SYMBOLS)) else $error("symbol count over capacity");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> last_out) else $error("error item not last");
`endif
endmodule

[verif/shannon_fano_code_builder_unit_test.sv]
// self-checking bench for the shannon-fano code builder: weight sets are sent in
// bursts, codes are predicted per set and compared with every result item
// depends on sfcb_pkg and shannon_fano_code_builder_unit
`timescale 1ns / 100ps

module shannon_fano_code_builder_unit_test;
  import sfcb_pkg::*;

  localparam int NSYM = 32;

  typedef struct packed {
    logic [4:0]  idx;
    logic [30:0] bits;
    logic [4:0]  len;
    status_t     st;
    logic        fin;
  } code_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] weight = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] symbol_index;
  logic [30:0] code_bits;
  logic [4:0] code_length;
  logic [1:0] status;
  logic last_out;

  shannon_fano_code_builder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .weight(weight), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .symbol_index(symbol_index),
    .code_bits(code_bits), .code_length(code_length), .status(status),
    .last_out(last_out)
  );

  // predictor state
  int unsigned sw [NSYM];
  int unsigned so [NSYM];
  int unsigned held;
  logic saw_zero, dropped;
  code_item_t pending_codes[$];

  int errors = 0, mismatches = 0, items_sent = 0, results_seen = 0, sets_sent = 0;
  int burst_left = 0;
  bit stall_on = 1'b0;

  initial forever #5 clk = ~clk;

  task automatic build_codes(input int n);
    longint sums [NSYM+1];
    logic [30:0] cw [NSYM];
    int cl [NSYM];
    int stk_lo [2*NSYM+2];
    int stk_hi [2*NSYM+2];
    int top, lo, hi, split;
    longint best_diff, l, r, d;
    code_item_t c;
    sums[0] = 0;
    for (int i = 0; i < n; i++) begin
      sums[i+1] = sums[i] + sw[i];
      cw[i] = '0;
      cl[i] = 0;
    end
    top = 1;
    stk_lo[0] = 0;
    stk_hi[0] = n;
    while (top > 0) begin
      top--;
      lo = stk_lo[top];
      hi = stk_hi[top];
      if (hi - lo < 2) continue;
      // first position with the smallest left/right difference
      split = lo + 1;
      best_diff = -1;
      for (int s = lo + 1; s < hi; s++) begin
        l = sums[s] - sums[lo];
        r = sums[hi] - sums[s];
        d = (l > r) ? l - r : r - l;
        if (best_diff < 0 || d < best_diff) begin
          best_diff = d;
          split = s;
        end
      end
      for (int i = lo; i < hi; i++)
        if (cl[i] < CODE_MAX_LEN) begin
          cw[i] = {cw[i][29:0], (i < split) ? 1'b1 : 1'b0};
          cl[i]++;
        end
      stk_lo[top] = split; stk_hi[top] = hi; top++;
      stk_lo[top] = lo; stk_hi[top] = split; top++;
    end
    for (int i = 0; i < n; i++) begin
      c.idx = so[i][4:0];
      c.bits = cw[i];
      c.len = cl[i][4:0];
      c.st = ST_OK;
      c.fin = (i == n - 1);
      pending_codes.insert(pending_codes.size(), c);
    end
  endtask

  task automatic predict_item(input logic [15:0] w, input logic l);
    int pos;
    code_item_t c;
    status_t st;
    if (w == 0) saw_zero = 1'b1;
    if (held < NSYM) begin
      // stable insertion by descending weight
      pos = held;
      while (pos > 0 && sw[pos-1] < w) begin
        sw[pos] = sw[pos-1];
        so[pos] = so[pos-1];
        pos--;
      end
      sw[pos] = 32'(w);
      so[pos] = held;
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (!l) return;
    sets_sent++;
    if (held < 2) st = ST_TOO_FEW;
    else if (saw_zero) st = ST_ZERO;
    else if (dropped) st = ST_TOO_MANY;
    else st = ST_OK;
    if (st != ST_OK) begin
      c = '0;
      c.st = st;
      c.fin = 1'b1;
      pending_codes.insert(pending_codes.size(), c);
    end else begin
      build_codes(held);
    end
    held = 0;
    saw_zero = 1'b0;
    dropped = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    code_item_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {symbol_index, code_bits, code_length, status_t'(status), last_out};
      results_seen++;
      if (pending_codes.size() == 0) begin
        errors++;
        if (mismatches++ < 10)
          $display("unexpected result item: idx %0d bits %h len %0d st %0d last %0b",
                   symbol_index, code_bits, code_length, status, last_out);
      end else begin
        want = pending_codes.pop_front();
        if (got != want) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp %0d %h %0d %0d %0b got %0d %h %0d %0d %0b",
                     want.idx, want.bits, want.len, want.st, want.fin,
                     got.idx, got.bits, got.len, got.st, got.fin);
        end
      end
    end
  end

  // receiver stall pattern: long runs of either always-ready or random stalls
  initial begin
    int run;
    forever begin
      stall_on = $urandom_range(0, 2) == 0;
      run = $urandom_range(20, 300);
      repeat (run) begin
        @(negedge clk);
        out_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
    end
  end

  // send one item; valid stays high afterwards unless a gap follows
  task automatic send_item(input logic [15:0] w, input logic l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 1)) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    weight <= w;
    last <= l;
    do @(posedge clk); while (!in_ready);
    predict_item(w, l);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_set(input int n, input int maxw, input bit allow_zero);
    logic [15:0] w;
    for (int i = 0; i < n; i++) begin
      w = 16'($urandom_range(allow_zero ? 0 : 1, maxw));
      send_item(w, i == n - 1);
    end
  endtask

  task automatic test_error_cases();
    send_item(16'd5, 1'b1);                        // single symbol
    send_item(16'd0, 1'b1);                        // single zero weight
    send_item(16'd3, 1'b0); send_item(16'd0, 1'b0); send_item(16'd7, 1'b1);
    for (int i = 0; i < NSYM + 2; i++)             // surplus items
      send_item(16'(i + 1), i == NSYM + 1);
    for (int i = 0; i < NSYM + 1; i++)             // zero among dropped items
      send_item((i == NSYM) ? 16'd0 : 16'd9, i == NSYM);
  endtask

  task automatic test_extremes();
    send_item(16'hffff, 1'b0); send_item(16'h0001, 1'b1);
    send_item(16'd4, 1'b0); send_item(16'd4, 1'b0); send_item(16'd4, 1'b1);
    send_item(16'h0001, 1'b0); send_item(16'hffff, 1'b0); send_item(16'h8000, 1'b0);
    send_item(16'h7fff, 1'b1);
  endtask

  task automatic test_full_set();
    for (int i = 0; i < NSYM; i++) send_item(16'hffff - 16'(i * 97), i == NSYM - 1);
    for (int i = 0; i < NSYM; i++) send_item(16'd1, i == NSYM - 1);
  endtask

  task automatic test_random_sets();
    int sel;
    while (items_sent < 420) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) send_set($urandom_range(2, 12), ($urandom_range(0, 1)) ? 16 : 65535, 0);
      else if (sel < 78) send_set($urandom_range(13, NSYM), 65535, 0);
      else if (sel < 86) send_set($urandom_range(2, 10), 3, 1);
      else if (sel < 92) send_set(1, 65535, 1);
      else send_set($urandom_range(NSYM + 1, NSYM + 4), 65535, 0);
      if (sets_sent % 25 == 0) wait_drained();
    end
  endtask

  initial begin
    held = 0;
    saw_zero = 1'b0;
    dropped = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_error_cases();
    test_extremes();
    test_full_set();
    wait_drained();
    test_random_sets();
    wait_drained();
    repeat (100) @(negedge clk);
    if (pending_codes.size() != 0) errors++;
    $display("sent %0d weight items in %0d sets, checked %0d result items",
             items_sent, sets_sent, results_seen);
    $display("sets covered good codes, too few, zero weight and surplus errors");
    if (errors == 0)
      $display("shannon_fano_code_builder_unit_test: clean");
    else
      $display("shannon_fano_code_builder_unit_test: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("shannon_fano_code_builder_unit_test: errors");
    $finish;
  end

endmodule
